>>> rtl/core/vwt_pkg.sv
// vertex weld table package: entry and config types, register indexes, match function
// no dependencies

package vwt_pkg;

  localparam int unsigned VWT_TABLE_DEPTH = 1024;
  localparam int unsigned VWT_IDX_W       = 10;
  localparam int unsigned VWT_TOL_W       = 16;
  localparam int unsigned VWT_CFG_IDX_W   = 2;

  localparam logic [VWT_TOL_W-1:0] VWT_TOL_RESET = 16'd7;

  // configuration register indexes
  typedef enum logic [VWT_CFG_IDX_W-1:0] {
    CFG_WELD_BY_POSITION  = 2'd0,
    CFG_WELD_ACROSS_VSETS = 2'd1,
    CFG_WELD_ACROSS_ISETS = 2'd2,
    CFG_MATCH_TOLERANCE   = 2'd3
  } vwt_cfg_idx_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } vwt_state_e;

  typedef struct packed {
    logic                 weld_by_position;
    logic                 weld_across_vertex_sets;
    logic                 weld_across_index_sets;
    logic [VWT_TOL_W-1:0] match_tolerance;
  } vwt_cfg_t;

  // one stored common vertex
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0]         vertex_set;
    logic [7:0]         index_set;
    logic [31:0]        original_index;
  } vwt_entry_t;

  localparam int unsigned VWT_ENTRY_W = $bits(vwt_entry_t);

  // |a - b| <= tol, difference formed on 33 bits so it never wraps
  function automatic logic within_tol(logic signed [31:0] a, logic signed [31:0] b,
                                      logic [VWT_TOL_W-1:0] tol);
    logic signed [32:0] diff;
    logic [32:0]        mag;
    diff = {a[31], a} - {b[31], b};
    mag  = diff[32] ? 33'(-diff) : 33'(diff);
    return mag <= {17'd0, tol};
  endfunction

  function automatic logic entry_match(vwt_entry_t st, vwt_entry_t rq, vwt_cfg_t cfg);
    logic pos_ok;
    pos_ok = within_tol(rq.pos_x, st.pos_x, cfg.match_tolerance) &&
             within_tol(rq.pos_y, st.pos_y, cfg.match_tolerance) &&
             within_tol(rq.pos_z, st.pos_z, cfg.match_tolerance);
    return pos_ok &&
           (st.vertex_set == rq.vertex_set || cfg.weld_across_vertex_sets) &&
           (st.index_set == rq.index_set || cfg.weld_across_index_sets) &&
           (st.original_index == rq.original_index || cfg.weld_by_position);
  endfunction

endpackage

>>> rtl/core/vwt_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module vwt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/vertex_weld_table_top.sv
// vertex weld table top level: sequencer, entry scan compare, config registers
// depends on vwt_pkg and vwt_ram

// Each transfer on the input channel is either a clear command or a
// find-or-insert of one vertex. A find-or-insert walks the stored common
// vertices in insertion order, one entry per clock through the single read
// port of the entry memory, and compares each against the request with one
// shared tolerance/rule compare unit. The first entry that matches ends the
// scan; with no match the vertex is appended, or table_full is reported when
// all TABLE_DEPTH entries are in use. A lookup goes through the scan state
// and then the finish state before its result loads the output register; a
// clear skips the scan and goes straight to the finish state. The
// block takes one item at a time: the input is stalled from the transfer
// until the result moves into the output register, which may still be
// holding the previous result. The entry memory needs no clearing pass:
// only entries below the fill count are ever compared. Configuration writes
// are always accepted and belong in idle periods.

module vertex_weld_table_top
  import vwt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = VWT_TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [VWT_CFG_IDX_W-1:0] cfg_index_i,
  input  logic [VWT_TOL_W-1:0]     cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic signed [31:0]       pos_x_i,
  input  logic signed [31:0]       pos_y_i,
  input  logic signed [31:0]       pos_z_i,
  input  logic [7:0]               vertex_set_i,
  input  logic [7:0]               index_set_i,
  input  logic [31:0]              original_index_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [VWT_IDX_W-1:0]     common_index_o,
  output logic                     inserted_o,
  output logic                     table_full_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  // configuration registers
  vwt_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weld_by_position        <= 1'b1;
      cfg_q.weld_across_vertex_sets <= 1'b1;
      cfg_q.weld_across_index_sets  <= 1'b1;
      cfg_q.match_tolerance         <= VWT_TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (vwt_cfg_idx_e'(cfg_index_i))
        CFG_WELD_BY_POSITION:  cfg_q.weld_by_position        <= cfg_data_i[0];
        CFG_WELD_ACROSS_VSETS: cfg_q.weld_across_vertex_sets <= cfg_data_i[0];
        CFG_WELD_ACROSS_ISETS: cfg_q.weld_across_index_sets  <= cfg_data_i[0];
        CFG_MATCH_TOLERANCE:   cfg_q.match_tolerance         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and scan state
  vwt_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;       // fill count
  logic [CW-1:0] scan_q, scan_d;     // next entry to read
  logic          rd_vld_q, rd_vld_d; // read data holds a live entry
  logic [AW-1:0] rd_idx_q, rd_idx_d; // index of that entry

  // request and pending result (payload, no reset)
  vwt_entry_t           req_q;
  logic [VWT_IDX_W-1:0] res_idx_q, res_idx_d;
  logic                 res_ins_q, res_ins_d;
  logic                 res_full_q, res_full_d;

  // output register
  logic                 out_vld_q, out_vld_d;
  logic [VWT_IDX_W-1:0] out_idx_q;
  logic                 out_ins_q;
  logic                 out_full_q;

  logic       in_xfer;
  logic       rd_req;
  logic       hit;
  logic       scan_end;
  logic       out_load;
  logic       ram_we;
  vwt_entry_t ram_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // shared compare unit, one stored entry per cycle
  assign rd_req   = (scan_q < cnt_q);
  assign hit      = rd_vld_q && entry_match(ram_rdata, req_q, cfg_q);
  assign scan_end = !rd_vld_q && !rd_req;
  assign out_load = (state_q == ST_FIN) && (!out_vld_q || !out_stall_i);
  assign ram_we   = (state_q == ST_SCAN) && scan_end && (cnt_q != DEPTH_CNT);

  vwt_ram #(
    .WIDTH (VWT_ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (req_q),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = cmd_i ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || scan_end) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cnt_d      = cnt_q;
    scan_d     = scan_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    res_idx_d  = res_idx_q;
    res_ins_d  = res_ins_q;
    res_full_d = res_full_q;
    out_vld_d  = out_vld_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          scan_d     = '0;
          res_idx_d  = '0;
          res_ins_d  = 1'b0;
          res_full_d = 1'b0;
          if (cmd_i) begin
            cnt_d = '0;
          end
        end
      end
      ST_SCAN: begin
        // issue the next read while the previous entry is compared
        if (rd_req) begin
          scan_d   = scan_q + CW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[AW-1:0];
        end
        if (hit) begin
          res_idx_d = VWT_IDX_W'(rd_idx_q);
        end else if (scan_end) begin
          if (cnt_q == DEPTH_CNT) begin
            res_full_d = 1'b1;
          end else begin
            res_idx_d = VWT_IDX_W'(cnt_q[AW-1:0]);
            res_ins_d = 1'b1;
            cnt_d     = cnt_q + CW'(1);
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      scan_q    <= scan_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q.pos_x          <= pos_x_i;
      req_q.pos_y          <= pos_y_i;
      req_q.pos_z          <= pos_z_i;
      req_q.vertex_set     <= vertex_set_i;
      req_q.index_set      <= index_set_i;
      req_q.original_index <= original_index_i;
    end
    rd_idx_q   <= rd_idx_d;
    res_idx_q  <= res_idx_d;
    res_ins_q  <= res_ins_d;
    res_full_q <= res_full_d;
    if (out_load) begin
      out_idx_q  <= res_idx_q;
      out_ins_q  <= res_ins_q;
      out_full_q <= res_full_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign common_index_o = out_idx_q;
  assign inserted_o     = out_ins_q;
  assign table_full_o   = out_full_q;

  // fill count never passes the table size
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_CNT)
    else $error("fill count above table depth");

  // an entry under compare was written before
  a_rd_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && rd_vld_q) |-> (CW'(rd_idx_q) < cnt_q))
    else $error("compare of an unwritten entry");

  // an append grows the table by exactly one
  a_append_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("append did not advance fill count");

  // a result never claims both insert and full
  a_res_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_ins_q && out_full_q))
    else $error("inserted and table_full both set");

endmodule
